>>> hdl/ptom_pkg.sv
// Shared types and codes for the price-time order matcher.
`default_nettype none
package ptom_pkg;

  // Request queue depth between front and back
  localparam int unsigned QDEPTH = 4;

  typedef enum logic [1:0] {
    TIF_GTC = 2'd0,
    TIF_IOC = 2'd1,
    TIF_FOK = 2'd2,
    TIF_MKT = 2'd3
  } tif_t;

  typedef enum logic [2:0] {
    EV_ACCEPTED  = 3'd0,
    EV_REJECTED  = 3'd1,
    EV_TRADE     = 3'd2,
    EV_FILLED    = 3'd3,
    EV_CANCELLED = 3'd4
  } ev_type_t;

  typedef enum logic [2:0] {
    RSN_NONE      = 3'd0,
    RSN_ZERO_QTY  = 3'd1,
    RSN_DUP_ID    = 3'd2,
    RSN_NO_QTY    = 3'd3,
    RSN_UNKNOWN   = 3'd4,
    RSN_BOOK_FULL = 3'd5
  } rsn_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MATCH,
    ST_FILL1,
    ST_FILL2,
    ST_REMAIN,
    ST_FINISH
  } eng_state_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic        is_cancel;
    logic [31:0] req_id;
    logic        side;
    tif_t        tif;
    logic [31:0] price;
    logic [31:0] qty;
  } req_t;

  // One event as produced by the engine
  typedef struct packed {
    ev_type_t    etype;
    logic [31:0] oid;
    logic [31:0] cid;
    logic [31:0] price;
    logic [31:0] qty;
    rsn_t        reason;
  } evt_t;

  // Push control from engine to output stage
  typedef struct packed {
    logic push;
    logic last;
  } evt_ctl_t;

endpackage
`default_nettype wire

>>> hdl/ptom_front.sv
// Front end: takes request beats, classifies them and queues them for the engine.
`default_nettype none
module ptom_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [103:0]  in_tdata,
  input  wire logic [0:0]    in_tuser,
  output logic               q_valid,
  output ptom_pkg::req_t     q_head,
  input  wire logic          q_pop
);
  import ptom_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  req_t            q_mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PW:0]     cnt_r;
  req_t            in_req;
  logic            push, pop;

  // Unpack and classify the incoming beat
  always_comb begin
    in_req.is_cancel = in_tuser[0];
    in_req.req_id    = in_tdata[31:0];
    in_req.side      = in_tdata[32];
    in_req.tif       = tif_t'(in_tdata[34:33]);
    in_req.price     = in_tdata[66:35];
    in_req.qty       = in_tdata[98:67];
  end

  assign in_tready = (cnt_r != (PW+1)'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_head    = q_mem_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= in_req;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ptom_out_stage.sv
// Output register: holds one event beat and stamps the sequence number.
`default_nettype none
module ptom_out_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ptom_pkg::evt_t ev,
  input  wire ptom_pkg::evt_ctl_t ctl,
  output logic                out_free,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [167:0]        out_tdata,
  output logic [2:0]          out_tuser,
  output logic                out_tlast
);
  import ptom_pkg::*;

  logic        valid_r;
  logic [31:0] seq_r;
  logic [31:0] seq_out_r;
  evt_t        ev_r;
  logic        last_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = ev_r.etype;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'd0, ev_r.reason, ev_r.qty, ev_r.price, ev_r.cid, ev_r.oid,
                       seq_out_r};

  // Payload
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ev_r      <= ev;
      last_r    <= ctl.last;
      seq_out_r <= seq_r + 32'd1;
    end
  end

  // Valid and running sequence count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      seq_r   <= '0;
    end else begin
      if (ctl.push) begin
        valid_r <= 1'b1;
        seq_r   <= seq_r + 32'd1;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ptom_engine.sv
// Back end: slot store, serial scans, matching sequencer and event ordering.
`default_nettype none
module ptom_engine #(
  parameter int unsigned BOOK_SLOTS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire ptom_pkg::req_t  q_head,
  output logic                 q_pop,
  input  wire logic            out_free,
  output ptom_pkg::evt_t       out_ev,
  output ptom_pkg::evt_ctl_t   out_ctl
);
  import ptom_pkg::*;

  localparam int unsigned IW = $clog2(BOOK_SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(BOOK_SLOTS - 1);

  // Slot store
  logic        sv_r    [BOOK_SLOTS];
  logic [31:0] s_id_r  [BOOK_SLOTS];
  logic        s_side_r[BOOK_SLOTS];
  logic [31:0] s_prc_r [BOOK_SLOTS];
  logic [31:0] s_qty_r [BOOK_SLOTS];
  logic [31:0] s_arr_r [BOOK_SLOTS];

  eng_state_t  state_r, state_nxt;
  req_t        req_r;
  logic        first_r;
  logic [IW-1:0] idx_r;
  logic [31:0] arrival_r;
  logic [31:0] rem_r;

  // Scan results
  logic          fnd_r;
  logic [IW-1:0] fidx_r;
  logic [31:0]   fprc_r, fqty_r;
  logic          free_v_r;
  logic [IW-1:0] free_idx_r;
  logic [32:0]   sum_r;
  logic          best_v_r;
  logic [IW-1:0] best_idx_r;
  logic [31:0]   best_prc_r, best_qty_r, best_id_r, best_age_r;

  // Pending event, held until the next one tells whether it was last
  logic        pend_v_r;
  evt_t        pend_r;

  // Scan element decode
  logic        c_v, c_side;
  logic [31:0] c_id, c_prc, c_qty, c_age;
  logic        c_match, c_opp, c_cross, c_better;
  logic [32:0] sum_add;
  logic        rs, buy;

  // Decision decode
  logic        fok_short, best_cross, q_gt, q_lt;
  logic        can_gen, gen_need, gen_fire, fin_fire, step_ok;
  evt_t        gen_ev;

  assign rs  = ~req_r.side;
  assign buy = ~req_r.side;

  always_comb begin
    c_v     = sv_r[idx_r];
    c_side  = s_side_r[idx_r];
    c_id    = s_id_r[idx_r];
    c_prc   = s_prc_r[idx_r];
    c_qty   = s_qty_r[idx_r];
    c_age   = arrival_r - s_arr_r[idx_r];
    c_match = c_v && (c_id == req_r.req_id);
    c_opp   = c_v && (c_side == rs);
    c_cross = buy ? (c_prc <= req_r.price) : (c_prc >= req_r.price);
    if (!best_v_r) begin
      c_better = 1'b1;
    end else if (c_prc != best_prc_r) begin
      c_better = rs ? (c_prc < best_prc_r) : (c_prc > best_prc_r);
    end else begin
      c_better = (c_age > best_age_r);
    end
    sum_add = sum_r + {1'b0, c_qty};
  end

  always_comb begin
    fok_short  = !sum_r[32] && (sum_r[31:0] < req_r.qty);
    best_cross = best_v_r && ((req_r.tif == TIF_MKT) ||
                 (buy ? (best_prc_r <= req_r.price) : (best_prc_r >= req_r.price)));
    q_gt       = best_qty_r > rem_r;
    q_lt       = best_qty_r < rem_r;
    can_gen    = !pend_v_r || out_free;
  end

  // Event generation per state
  always_comb begin
    gen_need = 1'b0;
    gen_ev   = '{etype: EV_REJECTED, oid: req_r.req_id, cid: 32'd0,
                 price: req_r.price, qty: req_r.qty, reason: RSN_NONE};
    unique case (state_r)
      ST_DECIDE: begin
        gen_need = 1'b1;
        if (req_r.is_cancel) begin
          if (fnd_r) begin
            gen_ev.etype = EV_CANCELLED;
            gen_ev.price = fprc_r;
            gen_ev.qty   = fqty_r;
          end else begin
            gen_ev.price  = 32'd0;
            gen_ev.qty    = 32'd0;
            gen_ev.reason = RSN_UNKNOWN;
          end
        end else if (req_r.qty == 32'd0) begin
          gen_ev.reason = RSN_ZERO_QTY;
        end else if (fnd_r) begin
          gen_ev.reason = RSN_DUP_ID;
        end else if (req_r.tif == TIF_FOK && fok_short) begin
          gen_ev.reason = RSN_NO_QTY;
        end else begin
          gen_ev.etype = EV_ACCEPTED;
        end
      end
      ST_MATCH: begin
        gen_need     = (rem_r != 32'd0) && best_cross;
        gen_ev.etype = EV_TRADE;
        gen_ev.cid   = best_id_r;
        gen_ev.price = best_prc_r;
        gen_ev.qty   = q_gt ? rem_r : best_qty_r;
      end
      ST_FILL1: begin
        gen_need     = 1'b1;
        gen_ev.etype = EV_FILLED;
        gen_ev.price = best_prc_r;
        if (q_gt) begin
          gen_ev.cid = best_id_r;
          gen_ev.qty = rem_r;
        end else begin
          gen_ev.oid = best_id_r;
          gen_ev.cid = req_r.req_id;
          gen_ev.qty = best_qty_r;
        end
      end
      ST_FILL2: begin
        gen_need     = 1'b1;
        gen_ev.etype = EV_FILLED;
        gen_ev.cid   = best_id_r;
        gen_ev.price = best_prc_r;
        gen_ev.qty   = best_qty_r;
      end
      ST_REMAIN: begin
        gen_ev.etype = EV_CANCELLED;
        gen_ev.qty   = rem_r;
        if (rem_r != 32'd0) begin
          if (req_r.tif == TIF_GTC) begin
            gen_need      = !free_v_r;
            gen_ev.reason = RSN_BOOK_FULL;
          end else if (req_r.tif == TIF_IOC || req_r.tif == TIF_MKT) begin
            gen_need = 1'b1;
          end
        end
      end
      default: ;
    endcase
    gen_fire = gen_need && can_gen;
    fin_fire = (state_r == ST_FINISH) && out_free;
    step_ok  = !gen_need || can_gen;
  end

  assign q_pop         = (state_r == ST_IDLE) && q_valid;
  assign out_ev        = pend_r;
  assign out_ctl.push  = (gen_fire && pend_v_r) || fin_fire;
  assign out_ctl.last  = fin_fire;

  // Next state; a rescan after a consumed resting order goes straight back to matching
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (idx_r == LAST_IDX) state_nxt = first_r ? ST_DECIDE : ST_MATCH;
      ST_DECIDE: begin
        if (step_ok) begin
          if (!req_r.is_cancel && req_r.qty != 32'd0 && !fnd_r &&
              !(req_r.tif == TIF_FOK && fok_short)) begin
            state_nxt = ST_MATCH;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_MATCH:  if (step_ok) state_nxt = gen_need ? ST_FILL1 : ST_REMAIN;
      ST_FILL1: begin
        if (step_ok) begin
          if (q_gt)      state_nxt = ST_REMAIN;
          else if (q_lt) state_nxt = ST_SCAN;
          else           state_nxt = ST_FILL2;
        end
      end
      ST_FILL2:  if (step_ok) state_nxt = ST_REMAIN;
      ST_REMAIN: if (step_ok) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pend_v_r  <= 1'b0;
      arrival_r <= '0;
      for (int i = 0; i < BOOK_SLOTS; i++) sv_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (gen_fire) pend_v_r <= 1'b1;
      else if (fin_fire) pend_v_r <= 1'b0;
      // Valid bit updates
      if (state_r == ST_DECIDE && step_ok && req_r.is_cancel && fnd_r) begin
        sv_r[fidx_r] <= 1'b0;
      end
      if (state_r == ST_FILL1 && step_ok && !q_gt) begin
        sv_r[best_idx_r] <= 1'b0;
      end
      if (state_r == ST_REMAIN && rem_r != 32'd0 && req_r.tif == TIF_GTC && free_v_r) begin
        sv_r[free_idx_r] <= 1'b1;
        arrival_r        <= arrival_r + 32'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (gen_fire) pend_r <= gen_ev;
    if (state_r == ST_IDLE && q_valid) begin
      req_r   <= q_head;
      first_r <= 1'b1;
    end
    // Scan start clears accumulators
    if ((state_r == ST_IDLE && q_valid) ||
        (state_r == ST_FILL1 && step_ok && q_lt)) begin
      idx_r    <= '0;
      fnd_r    <= 1'b0;
      free_v_r <= 1'b0;
      sum_r    <= '0;
      best_v_r <= 1'b0;
    end
    if (state_r == ST_SCAN) begin
      idx_r <= idx_r + 1'b1;
      if (c_match && !fnd_r) begin
        fnd_r  <= 1'b1;
        fidx_r <= idx_r;
        fprc_r <= c_prc;
        fqty_r <= c_qty;
      end
      if (!c_v && !free_v_r) begin
        free_v_r   <= 1'b1;
        free_idx_r <= idx_r;
      end
      if (c_opp && c_cross) begin
        sum_r <= sum_add[32] ? 33'h1_0000_0000 : sum_add;
      end
      if (c_opp && c_better) begin
        best_v_r   <= 1'b1;
        best_idx_r <= idx_r;
        best_prc_r <= c_prc;
        best_qty_r <= c_qty;
        best_id_r  <= c_id;
        best_age_r <= c_age;
      end
    end
    if (state_r == ST_DECIDE && first_r) begin
      rem_r   <= req_r.qty;
      first_r <= 1'b0;
    end
    // Match bookkeeping
    if (state_r == ST_FILL1 && step_ok) begin
      if (q_gt) begin
        s_qty_r[best_idx_r] <= best_qty_r - rem_r;
        rem_r               <= '0;
      end else begin
        rem_r <= rem_r - best_qty_r;
      end
    end
    // Rest a good-till-cancel remainder
    if (state_r == ST_REMAIN && rem_r != 32'd0 && req_r.tif == TIF_GTC && free_v_r) begin
      s_id_r[free_idx_r]   <= req_r.req_id;
      s_side_r[free_idx_r] <= req_r.side;
      s_prc_r[free_idx_r]  <= req_r.price;
      s_qty_r[free_idx_r]  <= rem_r;
      s_arr_r[free_idx_r]  <= arrival_r;
    end
  end

`ifndef ASSERT_OFF
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r <= LAST_IDX)
    else $error("scan index out of range");
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.push |-> out_free)
    else $error("event pushed into a busy output register");
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("pending event left over at idle");
  a_finish_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |-> pend_v_r)
    else $error("request finished without an event");
`endif

endmodule
`default_nettype wire

>>> hdl/price_time_order_matcher.sv
// Top level of the price-time priority order matcher.
`default_nettype none
// A request beat on the in_ side is queued (four deep) and then executed by a
// sequencer that walks the BOOK_SLOTS-entry order book one slot per cycle.
// A cancel or a rejected submit passes through pick-up, scan, decision and
// final beat. An accepted submit adds a match and a remainder step without a
// trade, a match, a fill and a remainder step with a partial fill, and a match,
// a first and a second fill and a remainder step when it exactly fills a resting
// order. Every resting order that a submit consumes while quantity is left
// adds another scan plus match and fill. A stalled sink holds the sequencer
// at its next event beat, and the queue keeps taking requests meanwhile.
// Events of a request leave in order with out_tlast on the last one; the
// sequence number starts at 1.
module price_time_order_matcher #(
  parameter int unsigned BOOK_SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // req_id[31:0], side[32], time_in_force[34:33], limit_price[66:35],
  // order_quantity[98:67], zero fill
  input  wire logic [103:0]  in_tdata,
  // req_type[0]
  input  wire logic [0:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // sequence_number[31:0], event_order_id[63:32], counter_order_id[95:64],
  // event_price[127:96], event_quantity[159:128], reject_reason[162:160], zero fill
  output logic [167:0]       out_tdata,
  // event_type[2:0]
  output logic [2:0]         out_tuser,
  // last_event
  output logic               out_tlast
);
  import ptom_pkg::*;

  logic     q_valid, q_pop, out_free;
  req_t     q_head;
  evt_t     ev;
  evt_ctl_t ctl;

  ptom_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .q_valid, .q_head, .q_pop
  );

  ptom_engine #(.BOOK_SLOTS(BOOK_SLOTS)) u_engine (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .out_free,
    .out_ev(ev), .out_ctl(ctl)
  );

  ptom_out_stage u_out (
    .clk, .rst_n, .ev, .ctl, .out_free,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

endmodule
`default_nettype wire
